// ----- src/atp_pkg.sv -----
// atp_pkg: widths, stage map and pipeline types of the transition point block
// used by accel_transition_point; no dependencies
`default_nettype none

package atp_pkg;

  // segment shape
  localparam int AXES   = 4;
  localparam int DW     = 32;

  // derived datapath widths
  localparam int SQ_W   = 2 * DW;
  localparam int SUM_W  = SQ_W + $clog2(AXES);
  localparam int LEN_W  = (SUM_W + 1) / 2;
  localparam int DEN_W  = DW + 1;
  localparam int DIFF_W = 2 * DW - 1;
  localparam int HI_W   = DIFF_W - DW;
  localparam int PH_W   = DW + HI_W;
  localparam int NUM_W  = DW + DIFF_W;
  localparam int AL_W   = DW + LEN_W;
  localparam int VF_W   = AL_W + 2;
  localparam int R2_W   = (VF_W + 1) / 2;
  localparam int SAT_W  = 2 * DW + 2;

  // stream widths
  localparam int IN_W   = (2 * AXES + 3) * DW;
  localparam int OUT_W  = (AXES + 1) * DW;

  // stage map
  localparam int ST_MUL  = 1;
  localparam int ST_INIT = 2;
  localparam int ST_A0   = 3;
  localparam int ST_PA   = ST_A0 + DIFF_W;
  localparam int ST_PB   = ST_PA + 1;
  localparam int ST_B0   = ST_PB + 1;
  localparam int NSTG    = ST_B0 + DIFF_W;

  // everything one segment carries down the pipeline
  typedef struct packed {
    logic [AXES-1:0][DW-1:0]     s;
    logic [AXES-1:0][DW-1:0]     e;
    logic [AXES-1:0][DW-1:0]     dmag;
    logic [AXES-1:0]             dneg;
    logic [DW-1:0]               v0;
    logic [DW-1:0]               v1;
    logic [DW-1:0]               a;
    logic                        zacc;
    logic                        same;
    logic [AXES-1:0][SQ_W-1:0]   sq;
    logic [SQ_W-1:0]             v0sq;
    logic [SQ_W-1:0]             v1sq;
    logic [SUM_W-1:0]            srem;
    logic [LEN_W-1:0]            sroot;
    logic [DIFF_W-1:0]           dnum;
    logic [DEN_W-1:0]            drem;
    logic [DEN_W-1:0]            dden;
    logic [DIFF_W-1:0]           dq;
    logic                        dnegd;
    logic [AXES-1:0][SQ_W-1:0]   plo;
    logic [AXES-1:0][PH_W-1:0]   phi;
    logic [AL_W-1:0]             al;
    logic [AXES-1:0][DIFF_W-1:0] anum;
    logic [AXES-1:0][LEN_W-1:0]  arem;
    logic [AXES-1:0][DIFF_W-1:0] aq;
    logic                        spos;
    logic                        seq;
    logic [VF_W-1:0]             vrem;
    logic [R2_W-1:0]             vroot;
  } pipe_t;

  // one result
  typedef struct packed {
    logic                    err;
    logic [DW-1:0]           speed;
    logic [AXES-1:0][DW-1:0] pt;
  } res_t;

endpackage

`default_nettype wire

// ----- src/accel_transition_point.sv -----
// accel_transition_point: pipelined transition point of a constant
// acceleration segment; depends on atp_pkg
`default_nettype none

// channel   dir  width  contents
// s_axis    in   352    start axes, end axes, start speed, end speed, accel
// m_axis    out  160+1  point axes, point speed; tuser same point error
//
// one request per cycle enters while the skid stage is empty
// the depth is set by the 63-step long divisions (distance, then per axis)
// and the bit-per-stage square roots that run beside them
// reset clears only the valid bits; payload registers are not reset
// a stalled result waits in the output register, one more in a skid stage,
// and the pipeline holds while the skid stage is full

module accel_transition_point (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // start_axis0..N, end_axis0..N, start_speed, end_speed, accel
  input  wire  [atp_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // point_axis0..N, point_speed
  output logic [atp_pkg::OUT_W-1:0]  m_axis_tdata,
  // same_point_error
  output logic                       m_axis_tuser
);

  localparam int AXES   = atp_pkg::AXES;
  localparam int DW     = atp_pkg::DW;
  localparam int NSTG   = atp_pkg::NSTG;

  function automatic logic [DW-1:0] mag32(input logic [DW-1:0] x);
    mag32 = x[DW-1] ? DW'(-x) : x;
  endfunction

  function automatic logic [DW-1:0] sat32(input logic signed [atp_pkg::SAT_W-1:0] x);
    logic signed [atp_pkg::SAT_W-1:0] hi;
    logic signed [atp_pkg::SAT_W-1:0] lo;
    hi = atp_pkg::SAT_W'($signed({1'b0, {(DW-1){1'b1}}}));
    lo = atp_pkg::SAT_W'($signed({1'b1, {(DW-1){1'b0}}}));
    if (x > hi) sat32 = hi[DW-1:0];
    else if (x < lo) sat32 = lo[DW-1:0];
    else sat32 = x[DW-1:0];
  endfunction

  atp_pkg::pipe_t p_q [NSTG];
  logic           v_q [NSTG];
  logic           ce;
  logic           skid_vq;
  atp_pkg::res_t  skid_q;
  atp_pkg::res_t  out_q;
  logic           out_vq;
  atp_pkg::res_t  fin;
  logic           fin_v;

  assign ce            = !skid_vq;
  assign s_axis_tready = ce;

  // stage 0: unpack, axis differences, special cases
  atp_pkg::pipe_t st0;
  always_comb begin
    logic [DW:0] d;
    logic        same;
    st0  = '0;
    same = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      st0.s[i] = s_axis_tdata[i*DW +: DW];
      st0.e[i] = s_axis_tdata[(AXES+i)*DW +: DW];
      d = {st0.e[i][DW-1], st0.e[i]} - {st0.s[i][DW-1], st0.s[i]};
      st0.dneg[i] = d[DW];
      st0.dmag[i] = d[DW] ? DW'(-d) : d[DW-1:0];
      if (d != '0) same = 1'b0;
    end
    st0.v0   = s_axis_tdata[(2*AXES)*DW +: DW];
    st0.v1   = s_axis_tdata[(2*AXES+1)*DW +: DW];
    st0.a    = s_axis_tdata[(2*AXES+2)*DW +: DW];
    st0.zacc = (st0.a == '0);
    st0.same = same;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ce) begin
      v_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) p_q[0] <= st0;
  end

  // stages 1 and up
  for (genvar k = 1; k < NSTG; k++) begin : g_stg
    localparam int JA  = k - atp_pkg::ST_A0;
    localparam int JB  = k - atp_pkg::ST_B0;
    localparam int SB1 = (JA >= 0 && JA < atp_pkg::LEN_W) ? atp_pkg::LEN_W - 1 - JA : 0;
    localparam int SB2 = (JB >= 0 && JB < atp_pkg::R2_W) ? atp_pkg::R2_W - 1 - JB : 0;

    atp_pkg::pipe_t nxt;

    always_comb begin
      atp_pkg::pipe_t              p;
      logic [atp_pkg::SUM_W-1:0]   sum;
      logic [atp_pkg::SQ_W:0]      diff;
      logic [atp_pkg::DEN_W:0]     td;
      logic [atp_pkg::LEN_W:0]     ta;
      logic [atp_pkg::SUM_W:0]     tr1;
      logic [atp_pkg::VF_W:0]      tr2;
      logic [atp_pkg::NUM_W-1:0]   num;
      logic [atp_pkg::VF_W-1:0]    v0x;
      logic [atp_pkg::VF_W-1:0]    al2;
      p   = p_q[k-1];
      nxt = p;
      sum = '0;
      diff = '0;
      td  = '0;
      ta  = '0;
      tr1 = '0;
      tr2 = '0;
      num = '0;
      v0x = '0;
      al2 = '0;
      if (k == atp_pkg::ST_MUL) begin
        // squares of axis differences and speeds
        for (int i = 0; i < AXES; i++) begin
          nxt.sq[i] = atp_pkg::SQ_W'(p.dmag[i]) * atp_pkg::SQ_W'(p.dmag[i]);
        end
        nxt.v0sq = atp_pkg::SQ_W'(mag32(p.v0)) * atp_pkg::SQ_W'(mag32(p.v0));
        nxt.v1sq = atp_pkg::SQ_W'(mag32(p.v1)) * atp_pkg::SQ_W'(mag32(p.v1));
      end else if (k == atp_pkg::ST_INIT) begin
        // length root and distance division set up
        for (int i = 0; i < AXES; i++) begin
          sum = sum + atp_pkg::SUM_W'(p.sq[i]);
        end
        nxt.srem  = sum;
        nxt.sroot = '0;
        diff = {1'b0, p.v1sq} - {1'b0, p.v0sq};
        nxt.dnegd = diff[atp_pkg::SQ_W] ^ p.a[DW-1];
        nxt.dnum  = diff[atp_pkg::SQ_W] ? atp_pkg::DIFF_W'(-diff)
                                        : diff[atp_pkg::DIFF_W-1:0];
        nxt.dden  = {mag32(p.a), 1'b0};
        nxt.drem  = '0;
        nxt.dq    = '0;
      end else if (k >= atp_pkg::ST_A0 && k < atp_pkg::ST_PA) begin
        // one distance quotient bit
        td = {p.drem, p.dnum[atp_pkg::DIFF_W-1]};
        nxt.dnum = {p.dnum[atp_pkg::DIFF_W-2:0], 1'b0};
        if (td >= {1'b0, p.dden}) begin
          nxt.drem = atp_pkg::DEN_W'(td - {1'b0, p.dden});
          nxt.dq   = {p.dq[atp_pkg::DIFF_W-2:0], 1'b1};
        end else begin
          nxt.drem = td[atp_pkg::DEN_W-1:0];
          nxt.dq   = {p.dq[atp_pkg::DIFF_W-2:0], 1'b0};
        end
        // one length root bit
        if (JA < atp_pkg::LEN_W) begin
          tr1 = (atp_pkg::SUM_W'(p.sroot) << (SB1 + 1))
              | ((atp_pkg::SUM_W+1)'(1) << (2 * SB1));
          if ({1'b0, p.srem} >= tr1) begin
            nxt.srem  = atp_pkg::SUM_W'({1'b0, p.srem} - tr1);
            nxt.sroot = p.sroot | (atp_pkg::LEN_W'(1) << SB1);
          end
        end
      end else if (k == atp_pkg::ST_PA) begin
        // axis by distance products, accel by length
        for (int i = 0; i < AXES; i++) begin
          nxt.plo[i] = atp_pkg::SQ_W'(p.dmag[i]) * atp_pkg::SQ_W'(p.dq[DW-1:0]);
          nxt.phi[i] = atp_pkg::PH_W'(p.dmag[i])
                     * atp_pkg::PH_W'(p.dq[atp_pkg::DIFF_W-1:DW]);
        end
        nxt.al = atp_pkg::AL_W'(mag32(p.a)) * atp_pkg::AL_W'(p.sroot);
      end else if (k == atp_pkg::ST_PB) begin
        // join partial products, end speed squared
        for (int i = 0; i < AXES; i++) begin
          num = (atp_pkg::NUM_W'(p.phi[i]) << DW) + atp_pkg::NUM_W'(p.plo[i]);
          nxt.arem[i] = atp_pkg::LEN_W'(num[atp_pkg::NUM_W-1:atp_pkg::DIFF_W]);
          nxt.anum[i] = num[atp_pkg::DIFF_W-1:0];
          nxt.aq[i]   = '0;
        end
        v0x = atp_pkg::VF_W'(p.v0sq);
        al2 = atp_pkg::VF_W'({p.al, 1'b0});
        if (!p.a[DW-1]) begin
          nxt.spos = 1'b1;
          nxt.seq  = 1'b0;
          nxt.vrem = v0x + al2;
        end else begin
          nxt.spos = (v0x > al2);
          nxt.seq  = (v0x == al2);
          nxt.vrem = (v0x > al2) ? v0x - al2 : '0;
        end
        nxt.vroot = '0;
      end else if (k >= atp_pkg::ST_B0) begin
        // one quotient bit per axis
        for (int i = 0; i < AXES; i++) begin
          ta = {p.arem[i], p.anum[i][atp_pkg::DIFF_W-1]};
          nxt.anum[i] = {p.anum[i][atp_pkg::DIFF_W-2:0], 1'b0};
          if (ta >= {1'b0, p.sroot}) begin
            nxt.arem[i] = atp_pkg::LEN_W'(ta - {1'b0, p.sroot});
            nxt.aq[i]   = {p.aq[i][atp_pkg::DIFF_W-2:0], 1'b1};
          end else begin
            nxt.arem[i] = ta[atp_pkg::LEN_W-1:0];
            nxt.aq[i]   = {p.aq[i][atp_pkg::DIFF_W-2:0], 1'b0};
          end
        end
        // one end speed root bit
        if (JB < atp_pkg::R2_W) begin
          tr2 = (atp_pkg::VF_W'(p.vroot) << (SB2 + 1))
              | ((atp_pkg::VF_W+1)'(1) << (2 * SB2));
          if ({1'b0, p.vrem} >= tr2) begin
            nxt.vrem  = atp_pkg::VF_W'({1'b0, p.vrem} - tr2);
            nxt.vroot = p.vroot | (atp_pkg::R2_W'(1) << SB2);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ce) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) p_q[k] <= nxt;
    end
  end

  // result selection and saturation
  always_comb begin
    atp_pkg::pipe_t p;
    logic           apos;
    logic           over;
    logic           neg;
    logic signed [atp_pkg::SAT_W-1:0] off;
    p    = p_q[NSTG-1];
    fin  = '0;
    apos = !p.a[DW-1] && !p.zacc;
    over = (apos && p.spos && ($signed({1'b0, p.vroot}) > $signed(p.v1)))
        || (p.a[DW-1] && !p.spos && !p.seq);
    neg  = 1'b0;
    off  = '0;
    if (p.zacc || p.same) begin
      fin.pt    = p.s;
      fin.speed = p.v0;
      fin.err   = !p.zacc && (p.v0 != p.v1);
    end else if (!over) begin
      fin.pt    = p.e;
      fin.speed = p.spos ? sat32(atp_pkg::SAT_W'(p.vroot)) : p.v1;
    end else begin
      for (int i = 0; i < AXES; i++) begin
        neg = p.dneg[i] ^ p.dnegd;
        off = $signed(atp_pkg::SAT_W'(p.aq[i]));
        if (neg) off = -off;
        fin.pt[i] = sat32(atp_pkg::SAT_W'($signed(p.s[i])) + off);
      end
      fin.speed = p.v1;
    end
  end

  assign fin_v = v_q[NSTG-1] && ce;

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (!out_vq || m_axis_tready) begin
      out_vq  <= skid_vq || fin_v;
      skid_vq <= 1'b0;
    end else if (fin_v) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vq || m_axis_tready) begin
      out_q <= skid_vq ? skid_q : fin;
    end else if (fin_v) begin
      skid_q <= fin;
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = {out_q.speed, out_q.pt};
  assign m_axis_tuser  = out_q.err;

endmodule

`default_nettype wire
